// File: rtl/wprd_pkg.sv
// Shared types and constants for the waveform peak/RMS decimator.
// No dependencies; used by every module under rtl.
package wprd_pkg;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PIXEL = 2'd2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned IDX_W = 13;
    localparam int unsigned SUM_W = 54;
    localparam int unsigned RMS_W = 16;

    // One closed bin handed from the front to the divide/root back end.
    typedef struct packed {
        logic [IDX_W-1:0] bin;
        logic [15:0]      mn;
        logic [15:0]      mx;
        logic [SUM_W-1:0] sum;
        logic [23:0]      cnt;
        logic             last;
    } t_bin;
endpackage

// File: rtl/waveform_peak_rms_decimator_core.sv
// Top level of the waveform peak/RMS decimator: config registers, front, back.
// Depends on wprd_pkg, wprd_front and wprd_back.
//
//  channel  | handshake          | word
//  ---------+--------------------+------------------------------------------
//  sample   | i_valid / o_ready  | i_sample_value
//  result   | o_valid / i_ready  | pixel_index, peak_low, peak_high, rms, last
//  config   | i_cfg_we           | i_cfg_index, i_cfg_data
//
// A closed bin occupies the back end while it is taken, through 54 divide steps
// and 27 root steps, until its word is presented, so samples stall while a closed
// bin waits for the back end to take it. After a change of sample or pixel count
// the start-step divider holds off samples until its division is done. Reset is
// synchronous and active low. Either side may stall at any time; words are held
// until taken.
module waveform_peak_rms_decimator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_sample_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_pixel_index,
    output logic [15:0] o_peak_low,
    output logic [15:0] o_peak_high,
    output logic [15:0] o_rms_level,
    output logic        o_run_last
);
    logic [23:0] r_n, r_s;
    logic [13:0] r_w;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= 24'd2; r_w <= 14'd2; r_s <= 24'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wprd_pkg::CFG_SAMPLE_COUNT:      r_n <= i_cfg_data;
                wprd_pkg::CFG_PIXEL_COUNT:       r_w <= i_cfg_data[13:0];
                wprd_pkg::CFG_SAMPLES_PER_PIXEL: r_s <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic           bvalid, bready;
    wprd_pkg::t_bin bin;

    wprd_front u_front (
        .i_clk, .i_rst_n, .i_n(r_n), .i_w(r_w), .i_s(r_s),
        .i_valid, .o_ready, .i_sample(i_sample_value),
        .o_bvalid(bvalid), .o_bin(bin), .i_bready(bready)
    );

    wprd_back u_back (
        .i_clk, .i_rst_n, .i_bvalid(bvalid), .o_bready(bready), .i_bin(bin),
        .o_valid, .i_ready, .o_pixel_index, .o_peak_low, .o_peak_high,
        .o_rms_level, .o_run_last
    );
endmodule

// File: rtl/wprd_front.sv
// Front end: bin scheduling and two accumulator lanes; emits closed bins.
// Depends on wprd_pkg.
module wprd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [23:0]          i_n,
    input  logic [13:0]          i_w,
    input  logic [23:0]          i_s,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_sample,
    output logic                 o_bvalid,
    output wprd_pkg::t_bin       o_bin,
    input  logic                 i_bready
);
    // Start step q,rm = (N-1)/(W-1): computed by a serial divider after reset and whenever N or W changes.
    logic [23:0] r_q;
    logic [12:0] r_rm;
    logic [23:0] r_dq, r_dr;
    logic [4:0]  r_dstep;
    logic        r_dbusy;
    logic [23:0] r_pn;
    logic [13:0] r_pw;
    logic [23:0] n_eff;
    logic [13:0] w_eff, span;
    logic [24:0] trial;
    always_comb begin
        n_eff = (i_n < 24'd2) ? 24'd2 : i_n;
        w_eff = (i_w < 14'd2) ? 14'd2 : ((i_w > 14'd8192) ? 14'd8192 : i_w);
        span  = w_eff - 14'd1;
        trial = {r_dr, r_dq[23]} - {11'd0, span};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0; r_pn <= '1; r_pw <= '1; r_dstep <= '0;
        end else if (!r_dbusy && (r_pn != n_eff || r_pw != w_eff)) begin
            r_pn <= n_eff; r_pw <= w_eff; r_dbusy <= 1'b1;
            r_dq <= n_eff - 24'd1; r_dr <= '0; r_dstep <= '0;
        end else if (r_dbusy) begin
            if (!trial[24]) begin
                r_dr <= trial[23:0]; r_dq <= {r_dq[22:0], 1'b1};
            end else begin
                r_dr <= {r_dr[22:0], r_dq[23]}; r_dq <= {r_dq[22:0], 1'b0};
            end
            r_dstep <= r_dstep + 5'd1;
            if (r_dstep == 5'd23) begin
                r_dbusy <= 1'b0;
                r_q <= trial[24] ? {r_dq[22:0], 1'b0} : {r_dq[22:0], 1'b1};
                r_rm <= trial[24] ? {r_dr[11:0], r_dq[23]} : trial[12:0];
            end
        end
    end

    logic [23:0] r_p, r_start;
    logic [13:0] r_next;
    logic [12:0] r_rem;
    logic [1:0]  r_act;
    logic [12:0] r_lbin [2];
    logic signed [15:0] r_lmn [2], r_lmx [2];
    logic [53:0] r_lsum [2];
    logic [23:0] r_lcnt [2];
    logic        r_pend;
    wprd_pkg::t_bin r_b2;

    logic [23:0] s_eff;
    logic        fend, open_b, take;
    logic [13:0] rsum;
    logic signed [15:0] x;
    logic [31:0] sq;
    logic [1:0]  opn, cl;
    logic [12:0] nb [2];
    logic signed [15:0] nmn [2], nmx [2];
    logic [53:0] nsum [2];
    logic [23:0] ncnt [2];
    wprd_pkg::t_bin bo [2];
    logic [23:0] n_p, n_start;
    logic [13:0] n_next;
    logic [12:0] n_rem;
    logic [1:0]  n_act;
    logic        n_bvalid, n_pend;
    wprd_pkg::t_bin n_bin, n_b2, b_lo, b_hi;
    always_comb begin
        s_eff = (i_s == 24'd0) ? 24'd1 : i_s;
        fend  = r_p >= n_eff - 24'd1;
        open_b = (r_next < w_eff) && (r_start <= r_p);
        x  = signed'(i_sample);
        sq = 32'(x) * 32'(x);
        opn = 2'b00;
        if (open_b) begin
            if (!r_act[0]) opn = 2'b01;
            else if (!r_act[1]) opn = 2'b10;
        end
        rsum = {1'b0, r_rem} + {1'b0, r_rm};
        for (int k = 0; k < 2; k++) begin
            nb[k] = opn[k] ? r_next[12:0] : r_lbin[k];
            if (opn[k]) begin
                nmn[k] = x; nmx[k] = x; nsum[k] = 54'(sq); ncnt[k] = 24'd1;
            end else begin
                nmn[k] = (x < r_lmn[k]) ? x : r_lmn[k];
                nmx[k] = (x > r_lmx[k]) ? x : r_lmx[k];
                nsum[k] = r_lsum[k] + 54'(sq);
                ncnt[k] = r_lcnt[k] + 24'd1;
            end
            cl[k] = (r_act[k] | opn[k]) && (ncnt[k] >= s_eff || fend);
            bo[k] = '{bin: nb[k], mn: nmn[k], mx: nmx[k], sum: nsum[k],
                      cnt: ncnt[k], last: 1'b1};
        end
        o_ready = !r_dbusy && !r_pend && (!o_bvalid || i_bready)
                  && r_pn == n_eff && r_pw == w_eff;
        take = i_valid && o_ready;

        // Frame position and the start of the next bin.
        n_p = r_p; n_start = r_start; n_next = r_next; n_rem = r_rem; n_act = r_act;
        if (take) begin
            if (open_b) begin
                n_next = r_next + 14'd1;
                if (rsum >= span) begin
                    n_rem = 13'(rsum - span);
                    n_start = r_start + r_q + 24'd1;
                end else begin
                    n_rem = rsum[12:0];
                    n_start = r_start + r_q;
                end
            end
            n_act = (r_act | opn) & ~cl;
            if (fend) begin
                n_p = '0; n_start = '0; n_next = '0; n_rem = '0; n_act = '0;
            end else begin
                n_p = r_p + 24'd1;
            end
        end

        // Two bins closing together leave in ascending pixel order.
        if (nb[1] < nb[0]) begin
            b_lo = bo[1]; b_hi = bo[0];
        end else begin
            b_lo = bo[0]; b_hi = bo[1];
        end
        n_bvalid = o_bvalid; n_bin = o_bin; n_pend = r_pend; n_b2 = r_b2;
        if (o_bvalid && i_bready) begin
            n_bvalid = r_pend; n_bin = r_b2; n_pend = 1'b0;
        end
        if (take) begin
            if (cl == 2'b11) begin
                n_bvalid = 1'b1; n_bin = b_lo; n_bin.last = 1'b0;
                n_b2 = b_hi; n_pend = 1'b1;
            end else if (cl[0]) begin
                n_bvalid = 1'b1; n_bin = bo[0];
            end else if (cl[1]) begin
                n_bvalid = 1'b1; n_bin = bo[1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= '0; r_start <= '0; r_next <= '0; r_rem <= '0; r_act <= '0;
            o_bvalid <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_p <= n_p; r_start <= n_start; r_next <= n_next; r_rem <= n_rem;
            r_act <= n_act;
            o_bvalid <= n_bvalid; r_pend <= n_pend;
            o_bin <= n_bin; r_b2 <= n_b2;
            if (take) begin
                for (int k = 0; k < 2; k++) begin
                    r_lbin[k] <= nb[k]; r_lmn[k] <= nmn[k]; r_lmx[k] <= nmx[k];
                    r_lsum[k] <= nsum[k]; r_lcnt[k] <= ncnt[k];
                end
            end
        end
    end

    a_pend_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> o_bvalid) else $error("second bin queued without first");
    a_no_take_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_ready) else $error("front accepted with queue full");
    a_div_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dbusy |-> !o_ready) else $error("accepted during step division");
endmodule

// File: rtl/wprd_back.sv
// Back end: divides the square sum by the count and takes the integer root.
// Depends on wprd_pkg.
module wprd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_bvalid,
    output logic                 o_bready,
    input  wprd_pkg::t_bin       i_bin,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [12:0]          o_pixel_index,
    output logic [15:0]          o_peak_low,
    output logic [15:0]          o_peak_high,
    output logic [15:0]          o_rms_level,
    output logic                 o_run_last
);
    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SQRT, ST_OUT} t_st;
    t_st r_st;
    logic [53:0] r_q, r_rem, r_v;
    logic [23:0] r_d;
    logic [5:0]  r_i;
    logic [16:0] r_res;
    logic [34:0] r_sr;
    wprd_pkg::t_bin r_b;
    logic [54:0] dt;
    logic [34:0] st;
    logic [17:0] cand;
    always_comb begin
        dt = {r_rem, r_q[53]} - {31'd0, r_d};
        cand = {r_res[15:0], 2'b01};
        st = {r_sr[32:0], r_v[53:52]} - {17'd0, cand};
        o_bready = (r_st == ST_IDLE);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready && r_st != ST_OUT) o_valid <= 1'b0;
            unique case (r_st)
                ST_IDLE: if (i_bvalid) begin
                    r_b <= i_bin; r_q <= i_bin.sum; r_rem <= '0;
                    r_d <= i_bin.cnt; r_i <= '0; r_st <= ST_DIV;
                end
                ST_DIV: begin
                    if (!dt[54]) begin
                        r_rem <= dt[53:0]; r_q <= {r_q[52:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[52:0], r_q[53]}; r_q <= {r_q[52:0], 1'b0};
                    end
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'd53) begin
                        r_st <= ST_SQRT; r_i <= '0; r_res <= '0; r_sr <= '0;
                        r_v <= dt[54] ? {r_q[52:0], 1'b0} : {r_q[52:0], 1'b1};
                    end
                end
                ST_SQRT: begin
                    if (!st[34]) begin
                        r_sr <= st; r_res <= {r_res[15:0], 1'b1};
                    end else begin
                        r_sr <= {r_sr[32:0], r_v[53:52]}; r_res <= {r_res[15:0], 1'b0};
                    end
                    r_v <= {r_v[51:0], 2'b00};
                    r_i <= r_i + 6'd1;
                    if (r_i == 6'd26) r_st <= ST_OUT;
                end
                ST_OUT: if (!o_valid || i_ready) begin
                    o_valid <= 1'b1; o_pixel_index <= r_b.bin;
                    o_peak_low <= r_b.mn; o_peak_high <= r_b.mx;
                    o_rms_level <= r_res[15:0]; o_run_last <= r_b.last;
                    r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_idle_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DIV) |-> !o_bready) else $error("took bin while busy");
    a_sqrt_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SQRT) |-> r_i <= 6'd26) else $error("root overran");
endmodule
